// File: hdl/jst_pkg.sv
// package for the job status table: constants, codes, beat types
`default_nettype none
package jst_pkg;
  localparam int unsigned JobCount = 4096;
  localparam int unsigned IdW = 12;
  localparam int unsigned RowW = 7;

  localparam logic [2:0] OP_CHANGE = 3'd0;
  localparam logic [2:0] OP_FORCE = 3'd1;
  localparam logic [2:0] OP_QUERY = 3'd2;
  localparam logic [2:0] OP_DONE_TAKE = 3'd3;
  localparam logic [2:0] OP_BORROW = 3'd4;
  localparam logic [2:0] OP_RETURN = 3'd5;
  localparam logic [2:0] OP_ADD_RANGE = 3'd6;
  localparam logic [2:0] OP_RET_PEND = 3'd7;

  localparam logic [2:0] ST_PEND = 3'd0;
  localparam logic [2:0] ST_RUN = 3'd1;
  localparam logic [2:0] ST_RET = 3'd2;
  localparam logic [2:0] ST_CAN = 3'd3;
  localparam logic [2:0] ST_FAIL = 3'd4;
  localparam logic [2:0] ST_DONE = 3'd5;
  localparam logic [2:0] ST_NONE = 3'd6;
  localparam int unsigned BORROW_BIT = 6;

  typedef struct packed {
    logic [2:0] op;
    logic [IdW-1:0] job_id;
    logic [IdW-1:0] range_end;
    logic [2:0] new_status;
  } in_beat_t;

  typedef struct packed {
    logic [IdW-1:0] out_job_id;
    logic [2:0] out_status;
    logic db_update;
    logic invalid;
  } out_beat_t;

  function automatic logic [2:0] row_query(input logic [RowW-1:0] r);
    logic [2:0] s;
    s = r[BORROW_BIT] ? ST_PEND : ST_NONE;
    for (int i = 0; i < 6; i++) begin
      if (r[i]) s = 3'(i);
    end
    return s;
  endfunction
endpackage
`default_nettype wire

// File: hdl/jst_ram.sv
// single port status memory with registered read data
`default_nettype none
module jst_ram #(
  parameter int unsigned Depth = 4096,
  parameter int unsigned Width = 7
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] addr,
  input  wire logic [Width-1:0]         wdata,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

// File: hdl/job_status_table_unit.sv
// job status table: command sequencer around the status memory
//
// channel | dir | beat type
// in_     | in  | jst_pkg::in_beat_t
// out_    | out | jst_pkg::out_beat_t
//
// after reset a clearing pass writes all 4096 rows, no beat taken
// single-entry ops: row read in S_RD, edited and written in S_MOD, result in S_OUT
// take and borrow scan one row per cycle above the scan position; a miss adds a
// check of all rows for returned jobs, a move of any to pending and a rescan;
// returned-to-pending is that check and move; move and range fill read then write each row
// in_ is taken only in idle; a held out_ beat stalls only the hand-off to out_
`default_nettype none
module job_status_table_unit (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire jst_pkg::in_beat_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output jst_pkg::out_beat_t      out_data
);
  localparam int unsigned IdW = jst_pkg::IdW;
  localparam int unsigned RowW = jst_pkg::RowW;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_RD, S_MOD, S_SCAN_RD, S_SCAN, S_RP_CHK, S_RP_MOVE,
    S_RANGE, S_TAKE, S_OUT
  } state_t;

  state_t state_r;
  jst_pkg::in_beat_t cmd_r;
  jst_pkg::out_beat_t res_r;
  jst_pkg::out_beat_t out_r;
  logic [IdW-1:0] scan_pos_r, idx_r, hi_r;
  logic [IdW:0] cnt_r;
  logic tries_r, any_r, borrow_r;
  logic [IdW-1:0] pidx_r;
  logic pv_r;
  logic ram_we;
  logic [IdW-1:0] ram_addr;
  logic [RowW-1:0] ram_wdata, ram_rdata;

  jst_ram #(.Depth(jst_pkg::JobCount), .Width(RowW)) u_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
  );

  // row edit for single-entry ops
  logic [RowW-1:0] nrow;
  logic [2:0] os;
  logic bad, db, pb, go_take;

  always_comb begin
    logic [RowW-1:0] r;
    logic [2:0] ns, q;
    r = ram_rdata;
    ns = cmd_r.new_status;
    q = jst_pkg::row_query(r);
    nrow = r;
    os = jst_pkg::ST_NONE;
    bad = 1'b0;
    db = 1'b0;
    pb = 1'b0;
    go_take = 1'b0;
    case (cmd_r.op)
      jst_pkg::OP_CHANGE: begin
        case (ns)
          jst_pkg::ST_PEND: begin
            os = q;
            if (q == jst_pkg::ST_NONE) begin
              nrow[0] = 1'b1; pb = 1'b1;
            end else if (q == jst_pkg::ST_RET || q == jst_pkg::ST_RUN) begin
              nrow[0] = 1'b1; nrow[q] = 1'b0; pb = 1'b1;
            end else bad = 1'b1;
          end
          jst_pkg::ST_RUN: begin
            if (r[0]) begin os = jst_pkg::ST_PEND; nrow[1] = 1'b1; nrow[0] = 1'b0; pb = 1'b1; end
            else if (r[2]) begin os = jst_pkg::ST_RET; nrow[1] = 1'b1; nrow[2] = 1'b0; end
            else if (r[3]) os = jst_pkg::ST_CAN;
            else bad = 1'b1;
          end
          jst_pkg::ST_RET: begin
            if (r[1]) begin os = jst_pkg::ST_RUN; nrow[2] = 1'b1; nrow[1] = 1'b0; end
            else if (r[3]) os = jst_pkg::ST_CAN;
            else if (r[4]) os = jst_pkg::ST_FAIL;
            else if (r[2]) os = jst_pkg::ST_RET;
            else if (r[5]) os = jst_pkg::ST_DONE;
            else bad = 1'b1;
          end
          jst_pkg::ST_CAN: begin
            if (r[0]) begin os = jst_pkg::ST_PEND; nrow[3] = 1'b1; nrow[0] = 1'b0; pb = 1'b1; end
            else if (r[1]) begin os = jst_pkg::ST_RUN; nrow[3] = 1'b1; nrow[1] = 1'b0; end
            else if (r[2]) begin os = jst_pkg::ST_RET; nrow[3] = 1'b1; nrow[2] = 1'b0; end
            else os = jst_pkg::ST_CAN;
          end
          jst_pkg::ST_FAIL: begin
            if (r[1]) begin os = jst_pkg::ST_RUN; nrow[4] = 1'b1; nrow[1] = 1'b0; end
            else if (r[2]) begin os = jst_pkg::ST_RET; nrow[4] = 1'b1; nrow[2] = 1'b0; end
            else os = jst_pkg::ST_FAIL;
          end
          jst_pkg::ST_DONE: begin
            if (r[1]) begin os = jst_pkg::ST_RUN; nrow[5] = 1'b1; nrow[1] = 1'b0; end
            else if (r[0]) begin os = jst_pkg::ST_PEND; nrow[5] = 1'b1; nrow[0] = 1'b0; end
            else if (r[2]) begin os = jst_pkg::ST_RET; nrow[5] = 1'b1; nrow[2] = 1'b0; end
            else if (r[3]) os = jst_pkg::ST_CAN;
            else if (r[4]) os = jst_pkg::ST_FAIL;
            else bad = 1'b1;
          end
          default: bad = 1'b1;
        endcase
      end
      jst_pkg::OP_FORCE: begin
        os = q;
        for (int i = 0; i < 6; i++) nrow[i] = (3'(i) == ns);
        nrow[jst_pkg::BORROW_BIT] = 1'b0;
      end
      jst_pkg::OP_QUERY: os = q;
      jst_pkg::OP_DONE_TAKE: begin
        os = q;
        go_take = 1'b1;
        if (r[1]) begin db = 1'b1; nrow[1] = 1'b0; nrow[5] = 1'b1; end
        else if (r[0]) begin db = 1'b1; nrow[0] = 1'b0; nrow[5] = 1'b1; end
        else if (r[2]) begin db = 1'b1; nrow[2] = 1'b0; nrow[5] = 1'b1; end
        else if (!(r[3] || r[4])) begin bad = 1'b1; go_take = 1'b0; end
      end
      jst_pkg::OP_RETURN: begin
        os = q;
        if (!r[jst_pkg::BORROW_BIT] || ns > jst_pkg::ST_DONE) bad = 1'b1;
        else begin
          nrow[jst_pkg::BORROW_BIT] = 1'b0;
          nrow[ns] = 1'b1;
          pb = (ns == jst_pkg::ST_PEND);
        end
      end
      default: ;
    endcase
  end

  logic pend_hit, last;
  assign pend_hit = ram_rdata[jst_pkg::ST_PEND];
  assign last = (idx_r == IdW'(jst_pkg::JobCount - 1));

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    ram_we = 1'b0;
    ram_addr = idx_r;
    ram_wdata = ram_rdata;
    case (state_r)
      S_CLEAR: begin ram_we = 1'b1; ram_wdata = '0; end
      S_RD: ram_addr = cmd_r.job_id;
      S_MOD: begin
        ram_addr = cmd_r.job_id;
        ram_we = !bad && cmd_r.op != jst_pkg::OP_QUERY && cmd_r.op != jst_pkg::OP_DONE_TAKE
                 ? 1'b1 : (cmd_r.op == jst_pkg::OP_DONE_TAKE && db);
        ram_wdata = nrow;
      end
      S_RP_MOVE: begin
        ram_we = pv_r && ram_rdata[jst_pkg::ST_RET];
        ram_wdata = ram_rdata;
        ram_wdata[jst_pkg::ST_RET] = 1'b0;
        ram_wdata[jst_pkg::ST_PEND] = 1'b1;
      end
      S_RANGE: begin ram_we = pv_r; ram_wdata[jst_pkg::ST_PEND] = 1'b1; end
      S_TAKE: begin
        ram_we = !pv_r;
        ram_wdata[jst_pkg::ST_PEND] = 1'b0;
        if (borrow_r) ram_wdata[jst_pkg::BORROW_BIT] = 1'b1;
        else ram_wdata[jst_pkg::ST_RUN] = 1'b1;
      end
      default: ;
    endcase
  end

  // memory read returns in the state after the address; scan and sweeps
  // read idx_r; the scan tracks the registered address copy pidx_r
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      idx_r <= '0;
      scan_pos_r <= '0;
      out_valid <= 1'b0;
      pv_r <= 1'b0;
    end else begin
      if (out_valid && out_ready && state_r != S_OUT) out_valid <= 1'b0;
      case (state_r)
        S_CLEAR: begin
          idx_r <= idx_r + 1'b1;
          if (last) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid && in_ready) begin
            cmd_r <= in_data;
            res_r <= '{out_job_id: '0, out_status: jst_pkg::ST_NONE, db_update: 1'b0,
                       invalid: 1'b0};
            tries_r <= 1'b0;
            case (in_data.op)
              jst_pkg::OP_BORROW: begin
                borrow_r <= 1'b1;
                state_r <= S_SCAN_RD;
              end
              jst_pkg::OP_ADD_RANGE: begin
                idx_r <= (in_data.job_id < in_data.range_end) ? in_data.job_id
                                                              : in_data.range_end;
                hi_r <= (in_data.job_id < in_data.range_end) ? in_data.range_end
                                                             : in_data.job_id;
                pv_r <= 1'b0;
                state_r <= S_RANGE;
              end
              jst_pkg::OP_RET_PEND: begin
                idx_r <= '0; any_r <= 1'b0; cnt_r <= '0;
                state_r <= S_RP_CHK;
              end
              jst_pkg::OP_DONE_TAKE: begin
                borrow_r <= 1'b0;
                state_r <= (in_data.job_id == '0) ? S_SCAN_RD : S_RD;
              end
              default: state_r <= S_RD;
            endcase
          end
        end
        S_RD: state_r <= S_MOD;
        S_MOD: begin
          res_r.out_status <= os;
          res_r.db_update <= db;
          res_r.invalid <= bad;
          if (pb && cmd_r.job_id < scan_pos_r)
            scan_pos_r <= (cmd_r.job_id == '0) ? '0 : cmd_r.job_id - 1'b1;
          state_r <= go_take ? S_SCAN_RD : S_OUT;
        end
        S_SCAN_RD: begin
          if (scan_pos_r == IdW'(jst_pkg::JobCount - 1)) begin
            state_r <= tries_r ? S_OUT : S_RP_CHK;
            idx_r <= '0; any_r <= 1'b0; cnt_r <= '0;
          end else begin
            idx_r <= scan_pos_r + 1'b1;
            pv_r <= 1'b0;
            state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          // pidx_r is the index whose data is on ram_rdata when pv_r
          pidx_r <= idx_r;
          pv_r <= 1'b1;
          if (pv_r && pend_hit) begin
            idx_r <= pidx_r;
            state_r <= S_TAKE;
          end else if (pv_r && pidx_r == IdW'(jst_pkg::JobCount - 1)) begin
            idx_r <= '0; any_r <= 1'b0; cnt_r <= '0;
            state_r <= tries_r ? S_OUT : S_RP_CHK;
          end else if (!last) begin
            idx_r <= idx_r + 1'b1;
          end
        end
        S_TAKE: begin
          // write phase needs the row of idx_r, which the registered read brings in the
          // next cycle, so S_TAKE first reads (pv_r set), then writes (pv_r clear)
          if (!pv_r) begin
            scan_pos_r <= idx_r;
            res_r.out_job_id <= idx_r;
            if (cmd_r.op == jst_pkg::OP_BORROW) res_r.out_status <= jst_pkg::ST_PEND;
            state_r <= S_OUT;
          end
          pv_r <= 1'b0;
        end
        S_RP_CHK: begin
          if (cnt_r != '0 && ram_rdata[jst_pkg::ST_RET]) any_r <= 1'b1;
          cnt_r <= cnt_r + 1'b1;
          if (!last) idx_r <= idx_r + 1'b1;
          if (cnt_r == (IdW+1)'(jst_pkg::JobCount)) begin
            idx_r <= '0;
            if (any_r || ram_rdata[jst_pkg::ST_RET]) begin
              scan_pos_r <= '0;
              pv_r <= 1'b0;
              state_r <= S_RP_MOVE;
            end else if (cmd_r.op == jst_pkg::OP_RET_PEND) state_r <= S_OUT;
            else begin
              tries_r <= 1'b1;
              state_r <= S_SCAN_RD;
            end
          end
        end
        S_RP_MOVE: begin
          // alternate read and write cycles per row
          pv_r <= !pv_r;
          if (pv_r) begin
            if (last) begin
              if (cmd_r.op == jst_pkg::OP_RET_PEND) state_r <= S_OUT;
              else begin
                tries_r <= 1'b1;
                state_r <= S_SCAN_RD;
              end
            end else idx_r <= idx_r + 1'b1;
          end
        end
        S_RANGE: begin
          // alternate read and write cycles per row
          pv_r <= !pv_r;
          if (pv_r) begin
            if (idx_r == hi_r || last) state_r <= S_OUT;
            else idx_r <= idx_r + 1'b1;
          end
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            out_r <= res_r;
            out_valid <= 1'b1;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_data = out_r;

  a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_ready) else $error("beat taken while busy");
  a_out_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT) |=> out_valid) else $error("result not shown");
  a_take_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_TAKE) |-> (idx_r != '0)) else $error("job zero taken");
endmodule
`default_nettype wire

// File: test/job_status_table_unit_tb.sv
// testbench for job_status_table_unit: directed table then random commands, scored by typed results or predictor
`timescale 1ns / 100ps
`default_nettype none
module job_status_table_unit_tb;
  localparam int unsigned IdW = jst_pkg::IdW;
  localparam int unsigned RowW = jst_pkg::RowW;
  localparam int unsigned JobCount = jst_pkg::JobCount;

  localparam logic [2:0] NO_CODE = 3'd7;
  localparam int RandomBeats = 480;
  localparam longint CycleLimit = 64'd40_000_000;

  typedef struct {
    jst_pkg::in_beat_t  beat;
    bit                 known;
    jst_pkg::out_beat_t want;
  } row_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  jst_pkg::in_beat_t in_data;
  logic out_valid;
  logic out_ready;
  jst_pkg::out_beat_t out_data;

  job_status_table_unit dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  logic [RowW-1:0] job_rows [JobCount];
  int unsigned scan_pos;
  jst_pkg::out_beat_t results_due [$];
  row_t plan [$];
  int errors;
  int beats_in;
  int beats_out;
  int op_seen [8];
  bit quiet;
  int out_stall;
  longint cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit has_bit(logic [IdW-1:0] id, int b);
    return job_rows[id][b];
  endfunction

  function automatic void set_bit(logic [IdW-1:0] id, int b, bit on);
    job_rows[id][b] = on;
  endfunction

  function automatic void set_pend_tracked(logic [IdW-1:0] id, logic [2:0] s, bit on);
    set_bit(id, s, on);
    if (s == jst_pkg::ST_PEND && id < scan_pos) scan_pos = (id != 0) ? id - 1 : 0;
  endfunction

  function automatic void move_state(logic [IdW-1:0] id, logic [2:0] to, logic [2:0] from);
    set_pend_tracked(id, to, 1'b1);
    set_pend_tracked(id, from, 1'b0);
  endfunction

  function automatic logic [2:0] job_state(logic [IdW-1:0] id);
    for (int s = 5; s >= 0; s--) begin
      if (has_bit(id, s)) return 3'(s);
    end
    return has_bit(id, jst_pkg::BORROW_BIT) ? jst_pkg::ST_PEND : jst_pkg::ST_NONE;
  endfunction

  function automatic logic [2:0] first_set(logic [IdW-1:0] id, logic [2:0] a, logic [2:0] b,
                                           logic [2:0] c);
    if (a < 6 && has_bit(id, a)) return a;
    if (b < 6 && has_bit(id, b)) return b;
    if (c < 6 && has_bit(id, c)) return c;
    return jst_pkg::ST_NONE;
  endfunction

  function automatic void requeue_returned();
    bit any;
    any = 1'b0;
    for (int i = 0; i < JobCount; i++) if (job_rows[i][jst_pkg::ST_RET]) any = 1'b1;
    if (!any) return;
    for (int i = 0; i < JobCount; i++) begin
      if (job_rows[i][jst_pkg::ST_RET]) begin
        job_rows[i][jst_pkg::ST_PEND] = 1'b1;
        job_rows[i][jst_pkg::ST_RET] = 1'b0;
      end
    end
    scan_pos = 0;
  endfunction

  function automatic logic [IdW-1:0] take_pending(bit borrow);
    for (int t = 0; t < 2; t++) begin
      for (int i = scan_pos + 1; i < JobCount; i++) begin
        if (job_rows[i][jst_pkg::ST_PEND]) begin
          job_rows[i][jst_pkg::ST_PEND] = 1'b0;
          job_rows[i][borrow ? jst_pkg::BORROW_BIT : jst_pkg::ST_RUN] = 1'b1;
          scan_pos = i;
          return IdW'(i);
        end
      end
      requeue_returned();
    end
    return '0;
  endfunction

  function automatic logic [2:0] checked_change(logic [IdW-1:0] id, logic [2:0] ns,
                                                ref bit bad);
    logic [2:0] old;
    case (ns)
      jst_pkg::ST_PEND: begin
        old = job_state(id);
        if (old == jst_pkg::ST_NONE) set_pend_tracked(id, jst_pkg::ST_PEND, 1'b1);
        else if (old == jst_pkg::ST_RET || old == jst_pkg::ST_RUN)
          move_state(id, jst_pkg::ST_PEND, old);
        else bad = 1'b1;
      end
      jst_pkg::ST_RUN: begin
        old = first_set(id, jst_pkg::ST_PEND, jst_pkg::ST_RET, jst_pkg::ST_CAN);
        if (old == jst_pkg::ST_NONE) bad = 1'b1;
        else if (old != jst_pkg::ST_CAN) move_state(id, jst_pkg::ST_RUN, old);
      end
      jst_pkg::ST_RET: begin
        old = first_set(id, jst_pkg::ST_RUN, jst_pkg::ST_CAN, jst_pkg::ST_FAIL);
        if (old == jst_pkg::ST_RUN) move_state(id, jst_pkg::ST_RET, old);
        if (old == jst_pkg::ST_NONE) begin
          old = first_set(id, jst_pkg::ST_RET, jst_pkg::ST_DONE, NO_CODE);
          if (old == jst_pkg::ST_NONE) bad = 1'b1;
        end
      end
      jst_pkg::ST_CAN: begin
        old = first_set(id, jst_pkg::ST_PEND, jst_pkg::ST_RUN, jst_pkg::ST_RET);
        if (old == jst_pkg::ST_NONE) old = jst_pkg::ST_CAN;
        else move_state(id, jst_pkg::ST_CAN, old);
      end
      jst_pkg::ST_FAIL: begin
        old = first_set(id, jst_pkg::ST_RUN, jst_pkg::ST_RET, NO_CODE);
        if (old == jst_pkg::ST_NONE) old = jst_pkg::ST_FAIL;
        else move_state(id, jst_pkg::ST_FAIL, old);
      end
      jst_pkg::ST_DONE: begin
        old = first_set(id, jst_pkg::ST_RUN, jst_pkg::ST_PEND, jst_pkg::ST_RET);
        if (old != jst_pkg::ST_NONE) begin
          set_bit(id, old, 1'b0);
          set_bit(id, jst_pkg::ST_DONE, 1'b1);
        end else begin
          old = first_set(id, jst_pkg::ST_CAN, jst_pkg::ST_FAIL, NO_CODE);
          if (old == jst_pkg::ST_NONE) bad = 1'b1;
        end
      end
      default: begin
        bad = 1'b1;
        old = jst_pkg::ST_NONE;
      end
    endcase
    return old;
  endfunction

  function automatic jst_pkg::out_beat_t apply_command(jst_pkg::in_beat_t b);
    jst_pkg::out_beat_t r;
    bit bad;
    logic [2:0] o;
    int lo;
    int hi;
    bad = 1'b0;
    r.out_job_id = '0;
    r.out_status = jst_pkg::ST_NONE;
    r.db_update = 1'b0;
    case (b.op)
      jst_pkg::OP_CHANGE: r.out_status = checked_change(b.job_id, b.new_status, bad);
      jst_pkg::OP_FORCE: begin
        r.out_status = job_state(b.job_id);
        for (int s = 0; s < 6; s++) set_bit(b.job_id, s, s == b.new_status);
        set_bit(b.job_id, jst_pkg::BORROW_BIT, 1'b0);
      end
      jst_pkg::OP_QUERY: r.out_status = job_state(b.job_id);
      jst_pkg::OP_DONE_TAKE: begin
        if (b.job_id != 0) begin
          r.out_status = job_state(b.job_id);
          r.db_update = 1'b1;
          if (has_bit(b.job_id, jst_pkg::ST_RUN)) begin
            set_bit(b.job_id, jst_pkg::ST_RUN, 1'b0);
            set_bit(b.job_id, jst_pkg::ST_DONE, 1'b1);
          end else begin
            o = first_set(b.job_id, jst_pkg::ST_PEND, jst_pkg::ST_RET, NO_CODE);
            if (o != jst_pkg::ST_NONE) begin
              set_bit(b.job_id, o, 1'b0);
              set_bit(b.job_id, jst_pkg::ST_DONE, 1'b1);
            end else begin
              r.db_update = 1'b0;
              if (first_set(b.job_id, jst_pkg::ST_CAN, jst_pkg::ST_FAIL, NO_CODE)
                  == jst_pkg::ST_NONE) bad = 1'b1;
            end
          end
        end
        if (!bad) r.out_job_id = take_pending(1'b0);
      end
      jst_pkg::OP_BORROW: begin
        r.out_job_id = take_pending(1'b1);
        r.out_status = (r.out_job_id != 0) ? jst_pkg::ST_PEND : jst_pkg::ST_NONE;
      end
      jst_pkg::OP_RETURN: begin
        r.out_status = job_state(b.job_id);
        if (!has_bit(b.job_id, jst_pkg::BORROW_BIT) || b.new_status > jst_pkg::ST_DONE) begin
          bad = 1'b1;
        end else begin
          set_bit(b.job_id, jst_pkg::BORROW_BIT, 1'b0);
          set_pend_tracked(b.job_id, b.new_status, 1'b1);
        end
      end
      jst_pkg::OP_ADD_RANGE: begin
        lo = (b.job_id < b.range_end) ? b.job_id : b.range_end;
        hi = (b.job_id < b.range_end) ? b.range_end : b.job_id;
        for (int i = lo; i <= hi; i++) job_rows[i][jst_pkg::ST_PEND] = 1'b1;
      end
      default: requeue_returned();
    endcase
    r.invalid = bad;
    return r;
  endfunction

  function automatic jst_pkg::in_beat_t mk(logic [2:0] op, int id, int rend, logic [2:0] ns);
    jst_pkg::in_beat_t b;
    b.op = op;
    b.job_id = IdW'(id);
    b.range_end = IdW'(rend);
    b.new_status = ns;
    return b;
  endfunction

  task automatic add_row(jst_pkg::in_beat_t b, bit known, logic [2:0] st, bit inv);
    row_t r;
    r.beat = b;
    r.known = known;
    r.want.out_job_id = '0;
    r.want.out_status = st;
    r.want.db_update = 1'b0;
    r.want.invalid = inv;
    plan.insert(plan.size(), r);
  endtask

  task automatic send(jst_pkg::in_beat_t b, bit known, jst_pkg::out_beat_t want);
    int gap;
    jst_pkg::out_beat_t pred;
    gap = quiet ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pred = apply_command(b);
    results_due.insert(results_due.size(), known ? want : pred);
    beats_in++;
    op_seen[b.op]++;
  endtask

  function automatic jst_pkg::in_beat_t random_beat();
    jst_pkg::in_beat_t b;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 25) b.op = jst_pkg::OP_CHANGE;
    else if (pick < 33) b.op = jst_pkg::OP_FORCE;
    else if (pick < 43) b.op = jst_pkg::OP_QUERY;
    else if (pick < 58) b.op = jst_pkg::OP_DONE_TAKE;
    else if (pick < 68) b.op = jst_pkg::OP_BORROW;
    else if (pick < 85) b.op = jst_pkg::OP_RETURN;
    else if (pick < 94) b.op = jst_pkg::OP_ADD_RANGE;
    else b.op = jst_pkg::OP_RET_PEND;
    b.job_id = ($urandom_range(0, 9) == 0) ? IdW'($urandom) : IdW'($urandom_range(0, 31));
    if ($urandom_range(0, 7) == 0) b.range_end = IdW'($urandom);
    else b.range_end = IdW'(b.job_id + $urandom_range(0, 12));
    b.new_status = ($urandom_range(0, 15) == 0) ? 3'($urandom) : 3'($urandom_range(0, 5));
    return b;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("job_status_table_unit_tb: done, errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    jst_pkg::out_beat_t want;
    int nxt;
    nxt = out_stall;
    if (rst_n && out_valid && out_ready) begin
      beats_out++;
      if (results_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat, exp none, got %p", $time, out_data);
      end else begin
        want = results_due.pop_front();
        if (out_data !== want) begin
          errors++;
          $display("%0t: mismatch exp job %0d st %0d db %0b inv %0b,", $time,
                   want.out_job_id, want.out_status, want.db_update, want.invalid);
          $display("%0t:          got job %0d st %0d db %0b inv %0b", $time,
                   out_data.out_job_id, out_data.out_status, out_data.db_update,
                   out_data.invalid);
        end
      end
      nxt = quiet ? 0 : $urandom_range(0, 8);
    end
    if (nxt > 0) begin
      out_ready <= 1'b0;
      out_stall <= nxt - 1;
    end else begin
      out_ready <= 1'b1;
      out_stall <= 0;
    end
  end

  initial begin
    jst_pkg::out_beat_t none;
    none = '0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    out_stall = 0;
    cycles = 0;
    errors = 0;
    beats_in = 0;
    beats_out = 0;
    quiet = 1'b0;
    scan_pos = 0;
    foreach (op_seen[i]) op_seen[i] = 0;
    for (int i = 0; i < JobCount; i++) job_rows[i] = '0;

    // rows with typed results run on the empty table
    add_row(mk(jst_pkg::OP_QUERY, 5, 0, jst_pkg::ST_PEND), 1, jst_pkg::ST_NONE, 0);
    add_row(mk(jst_pkg::OP_QUERY, 4095, 4095, jst_pkg::ST_DONE), 1, jst_pkg::ST_NONE, 0);
    add_row(mk(jst_pkg::OP_CHANGE, 1, 0, jst_pkg::ST_RUN), 1, jst_pkg::ST_NONE, 1);
    add_row(mk(jst_pkg::OP_RETURN, 7, 0, jst_pkg::ST_PEND), 1, jst_pkg::ST_NONE, 1);
    add_row(mk(jst_pkg::OP_CHANGE, 2, 0, NO_CODE), 1, jst_pkg::ST_NONE, 1);
    add_row(mk(jst_pkg::OP_DONE_TAKE, 0, 0, jst_pkg::ST_PEND), 1, jst_pkg::ST_NONE, 0);
    add_row(mk(jst_pkg::OP_DONE_TAKE, 9, 0, jst_pkg::ST_PEND), 1, jst_pkg::ST_NONE, 1);
    add_row(mk(jst_pkg::OP_BORROW, 0, 0, jst_pkg::ST_PEND), 1, jst_pkg::ST_NONE, 0);
    add_row(mk(jst_pkg::OP_ADD_RANGE, 20, 3, jst_pkg::ST_PEND), 0, jst_pkg::ST_NONE, 0);
    add_row(mk(jst_pkg::OP_ADD_RANGE, 4095, 4090, jst_pkg::ST_PEND), 0, jst_pkg::ST_NONE, 0);
    add_row(mk(jst_pkg::OP_ADD_RANGE, 0, 0, jst_pkg::ST_PEND), 0, jst_pkg::ST_NONE, 0);
    add_row(mk(jst_pkg::OP_DONE_TAKE, 0, 0, jst_pkg::ST_PEND), 0, jst_pkg::ST_NONE, 0);
    add_row(mk(jst_pkg::OP_BORROW, 0, 0, jst_pkg::ST_PEND), 0, jst_pkg::ST_NONE, 0);
    add_row(mk(jst_pkg::OP_RETURN, 4, 0, jst_pkg::ST_RET), 0, jst_pkg::ST_NONE, 0);
    add_row(mk(jst_pkg::OP_CHANGE, 3, 0, jst_pkg::ST_RUN), 0, jst_pkg::ST_NONE, 0);
    add_row(mk(jst_pkg::OP_CHANGE, 3, 0, jst_pkg::ST_RET), 0, jst_pkg::ST_NONE, 0);
    add_row(mk(jst_pkg::OP_CHANGE, 5, 0, jst_pkg::ST_CAN), 0, jst_pkg::ST_NONE, 0);
    add_row(mk(jst_pkg::OP_CHANGE, 6, 0, jst_pkg::ST_FAIL), 0, jst_pkg::ST_NONE, 0);
    add_row(mk(jst_pkg::OP_CHANGE, 7, 0, jst_pkg::ST_DONE), 0, jst_pkg::ST_NONE, 0);
    add_row(mk(jst_pkg::OP_FORCE, 8, 0, NO_CODE), 0, jst_pkg::ST_NONE, 0);
    add_row(mk(jst_pkg::OP_FORCE, 4095, 0, jst_pkg::ST_DONE), 0, jst_pkg::ST_NONE, 0);
    add_row(mk(jst_pkg::OP_RET_PEND, 0, 0, jst_pkg::ST_PEND), 0, jst_pkg::ST_NONE, 0);
    add_row(mk(jst_pkg::OP_DONE_TAKE, 4095, 0, jst_pkg::ST_PEND), 0, jst_pkg::ST_NONE, 0);
    add_row(mk(jst_pkg::OP_BORROW, 0, 0, jst_pkg::ST_PEND), 0, jst_pkg::ST_NONE, 0);
    add_row(mk(jst_pkg::OP_RETURN, 2, 0, jst_pkg::ST_NONE), 0, jst_pkg::ST_NONE, 0);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) send(plan[i].beat, plan[i].known, plan[i].want);
    in_valid <= 1'b0;
    // hold off until the table has answered everything
    while (results_due.size() != 0) @(posedge clk);

    for (int n = 0; n < RandomBeats; n++) begin
      if (n % 100 == 50) quiet = ~quiet;
      send(random_beat(), 0, none);
    end
    in_valid <= 1'b0;

    while (results_due.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    $display("%0d commands sent, %0d results scored, %0d mismatches", beats_in, beats_out,
             errors);
    $display("per op: chg %0d frc %0d qry %0d take %0d brw %0d ret %0d rng %0d requeue %0d",
             op_seen[0], op_seen[1], op_seen[2], op_seen[3], op_seen[4], op_seen[5],
             op_seen[6], op_seen[7]);
    if (errors == 0) begin
      $display("job_status_table_unit_tb: done, clean");
    end else begin
      $display("job_status_table_unit_tb: done, errors");
    end
    $finish;
  end
endmodule
`default_nettype wire

// File: files.f
hdl/jst_pkg.sv
hdl/jst_ram.sv
hdl/job_status_table_unit.sv
test/job_status_table_unit_tb.sv
